// ===== rtl/two_button_short_long_press_nav_unit_defines.svh =====
// Assertion macros used by the checker in tbnav_chk.sv.
`ifndef TWO_BUTTON_SHORT_LONG_PRESS_NAV_UNIT_DEFINES_SVH
`define TWO_BUTTON_SHORT_LONG_PRESS_NAV_UNIT_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define TBNAV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tbnav: check failed");

// Clocked check with its own message.
`define TBNAV_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== rtl/tbnav_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tbnav_pkg;

  localparam int unsigned IdxW   = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgIdW = 2;
  localparam int unsigned CfgDW  = 16;
  localparam int unsigned InDW   = 40;
  localparam int unsigned OutDW  = 24;

  localparam logic [HoldW-1:0] HOLD_TIME_RESET = 16'd400;

  localparam logic [CfgIdW-1:0] REG_ITEM_COUNT   = 2'd0;
  localparam logic [CfgIdW-1:0] REG_HOLD_TIME    = 2'd1;
  localparam logic [CfgIdW-1:0] REG_BOTH_CANCELS = 2'd2;

  // Press tracking of one button.
  typedef struct packed {
    logic             was_down;
    logic             long_done;
    logic [TimeW-1:0] hold_start;
  } btn_state_t;

  // What one sample does to one button.
  typedef struct packed {
    btn_state_t nxt;
    logic       long_pulse;
    logic       short_press;
  } btn_result_t;

endpackage

`default_nettype wire

// ===== rtl/tbnav_btn.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Short/long press classifier for one button, pure next-state logic.
module tbnav_btn import tbnav_pkg::*; (
  input  wire logic             down_i,
  input  wire logic [TimeW-1:0] now_i,
  input  wire logic [HoldW-1:0] hold_time_i,
  input  wire btn_state_t       cur_i,
  output btn_result_t           res_o
);

  logic [TimeW-1:0] elapsed;
  logic             held_long;

  // modulo 2^32, so a wrapped timestamp still measures correctly
  assign elapsed   = now_i - cur_i.hold_start;
  assign held_long = elapsed >= {{(TimeW-HoldW){1'b0}}, hold_time_i};

  always_comb begin
    res_o                = '0;
    res_o.nxt.was_down   = down_i;
    res_o.nxt.hold_start = cur_i.hold_start;
    res_o.nxt.long_done  = cur_i.long_done;
    if (down_i) begin
      if (!cur_i.was_down) begin
        res_o.nxt.hold_start = now_i;
        res_o.nxt.long_done  = 1'b0;
      end else if (!cur_i.long_done && (cur_i.hold_start != '0) && held_long) begin
        // a zero start means the timer never runs
        res_o.long_pulse    = 1'b1;
        res_o.nxt.long_done = 1'b1;
      end
    end else begin
      res_o.short_press    = cur_i.was_down && !cur_i.long_done;
      res_o.nxt.hold_start = '0;
      res_o.nxt.long_done  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/two_button_short_long_press_nav_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-button navigator: each sample of the next/previous buttons with a ms
// timestamp gives one result in the cycle after its transfer, and a new
// sample is taken every cycle while the result register is empty or being
// drained; the selection and press-tracking registers close a loop. A release
// without a long press steps the selection (next before previous within one
// sample), holding a button for hold_time_ms fires one long-press pulse.
// item_count of zero ignores samples; writing item_count clears selection and
// tracking. Input tdata: [0] next_down, [1] prev_down, [33:2] now_ms.
// Output tdata: [7:0] selected_index, [15:8] previous_index,
// [16] selection_changed, [17] open_selected, [18] go_back.
// Config registers: 0 item_count, 1 hold_time_ms, 2 both_down_cancels.
module two_button_short_long_press_nav_unit import tbnav_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] next_down, [1] prev_down, [33:2] now_ms, [39:34] zero
  input  wire logic [InDW-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [7:0] selected_index, [15:8] previous_index, [16] selection_changed,
  // [17] open_selected, [18] go_back, [23:19] zero
  output logic [OutDW-1:0]       m_axis_tdata,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgIdW-1:0] cfg_index_i,
  input  wire logic [CfgDW-1:0]  cfg_data_i
);

  logic [IdxW-1:0]  item_count_q;
  logic [HoldW-1:0] hold_time_q;
  logic             both_cancel_q;
  logic [IdxW-1:0]  sel_q, sel_d;
  btn_state_t       next_q, next_d, prev_q, prev_d;
  logic             out_valid_q;
  logic [OutDW-1:0] out_data_q, out_data_d;

  logic             in_fire, cfg_fire, clear_all;
  logic             nd, pd;
  logic [TimeW-1:0] now;
  btn_result_t      next_res, prev_res;
  logic [IdxW:0]    sel_inc;
  logic [IdxW-1:0]  sel_mid;
  logic             changed, open_pulse, back_pulse;

  assign nd  = s_axis_tdata[0];
  assign pd  = s_axis_tdata[1];
  assign now = s_axis_tdata[TimeW+1:2];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign clear_all     = cfg_fire && (cfg_index_i == REG_ITEM_COUNT);

  tbnav_btn u_next (
    .down_i      (nd),
    .now_i       (now),
    .hold_time_i (hold_time_q),
    .cur_i       (next_q),
    .res_o       (next_res)
  );

  tbnav_btn u_prev (
    .down_i      (pd),
    .now_i       (now),
    .hold_time_i (hold_time_q),
    .cur_i       (prev_q),
    .res_o       (prev_res)
  );

  assign sel_inc = {1'b0, sel_q} + {{IdxW{1'b0}}, 1'b1};

  always_comb begin
    sel_d      = sel_q;
    next_d     = next_q;
    prev_d     = prev_q;
    changed    = 1'b0;
    open_pulse = 1'b0;
    back_pulse = 1'b0;
    sel_mid    = sel_q;
    if (item_count_q != '0) begin
      if (both_cancel_q && nd && pd) begin
        next_d = '0;
        prev_d = '0;
      end else begin
        if (next_res.short_press) begin
          sel_mid = (sel_inc < {1'b0, item_count_q}) ? sel_inc[IdxW-1:0] : '0;
        end
        sel_d = sel_mid;
        if (prev_res.short_press) begin
          sel_d = (sel_mid != '0) ? (sel_mid - IdxW'(1'b1)) :
                                    (item_count_q - IdxW'(1'b1));
        end
        changed    = next_res.short_press || prev_res.short_press;
        open_pulse = next_res.long_pulse;
        back_pulse = prev_res.long_pulse;
        next_d     = next_res.nxt;
        prev_d     = prev_res.nxt;
      end
    end
    out_data_d = {{(OutDW-2*IdxW-3){1'b0}}, back_pulse, open_pulse, changed, sel_q, sel_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q  <= '0;
      hold_time_q   <= HOLD_TIME_RESET;
      both_cancel_q <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_ITEM_COUNT:   item_count_q  <= cfg_data_i[IdxW-1:0];
        REG_HOLD_TIME:    hold_time_q   <= cfg_data_i[HoldW-1:0];
        REG_BOTH_CANCELS: both_cancel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      next_q <= '0;
      prev_q <= '0;
    end else if (clear_all) begin
      sel_q  <= '0;
      next_q <= '0;
      prev_q <= '0;
    end else if (in_fire) begin
      sel_q  <= sel_d;
      next_q <= next_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/tbnav_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "two_button_short_long_press_nav_unit_defines.svh"

module tbnav_chk import tbnav_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic [InDW-1:0]   s_axis_tdata,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [OutDW-1:0]  m_axis_tdata,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic [CfgIdW-1:0] cfg_index_i,
  input wire logic [CfgDW-1:0]  cfg_data_i
);

  logic unused_ok;
  logic in_xfer, blocked, out_quiet, idx_same;

  assign unused_ok = ^{s_axis_tdata, cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i};

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign blocked   = m_axis_tvalid && !m_axis_tready;
  assign out_quiet = m_axis_tvalid && !m_axis_tdata[16];
  assign idx_same  = m_axis_tdata[7:0] == m_axis_tdata[15:8];

  // a stalled result stays put
  `TBNAV_ASSERT(a_out_hold, blocked |=> m_axis_tvalid && $stable(m_axis_tdata))

  // every sample transfer shows up as a result the next cycle
  `TBNAV_ASSERT_MSG(a_in_to_out, in_xfer |=> m_axis_tvalid, "tbnav: result missing")

  // input stalls only behind a blocked result
  `TBNAV_ASSERT(a_stall_cause, !s_axis_tready |-> blocked)

  // no step flagged means the index did not move
  `TBNAV_ASSERT_MSG(a_idx_steady, out_quiet |-> idx_same, "tbnav: index moved without a step")

endmodule

bind two_button_short_long_press_nav_unit tbnav_chk u_tbnav_chk (.*);

`default_nettype wire

// ===== bench/two_button_short_long_press_nav_unit_tb.sv =====
`timescale 1ns / 1ps

module two_button_short_long_press_nav_unit_tb import tbnav_pkg::*; ();

  localparam logic [CfgIdW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RAND_ITEMS = 1720;
  localparam int unsigned LONG_HOLD  = 80;
  localparam int unsigned CFG_SETTLE = 4;

  typedef struct packed {
    logic [IdxW-1:0] sel_idx;
    logic [IdxW-1:0] prev_idx;
    logic            changed;
    logic            open_sel;
    logic            go_back;
  } nav_res_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CfgIdW-1:0] reg_id;
    logic [CfgDW-1:0]  val;
    logic              nd;
    logic              pd;
    logic [TimeW-1:0]  now;
    logic              typed;
    nav_res_t          want;
  } dir_row_t;

  localparam int DIR_N = 39;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // unconfigured: samples leave everything alone
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd0, 1'b1,
      '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd5, 1'b1,
      '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd6, 1'b1,
      '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_WRITE,  REG_UNUSED,       16'hFFFF, 1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_WRITE,  REG_ITEM_COUNT,   16'd3,    1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_WRITE,  REG_HOLD_TIME,    16'd10,   1'b0, 1'b0, 32'd0, 1'b0, '0},
    // press at time zero has no timer, release is a short press
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd0,    1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd1000, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd1001, 1'b0, '0},
    // long press of next, then release without a step
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd100, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd110, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd201, 1'b0, '0},
    // short prev presses, second one wraps below zero
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b1, 32'd300, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd301, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b1, 32'd302, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd303, 1'b0, '0},
    // long prev across the 32-bit time wrap
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b1, 32'hFFFF_FFF0, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b1, 32'd5, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd6, 1'b0, '0},
    // both released in one sample: next then prev
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b1, 32'd500, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd501, 1'b0, '0},
    '{ROW_WRITE,  REG_BOTH_CANCELS, 16'd1, 1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b1, 32'd600, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd601, 1'b0, '0},
    // zero hold time fires on the second held sample
    '{ROW_WRITE,  REG_HOLD_TIME,    16'd0,  1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd700, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd700, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd701, 1'b0, '0},
    '{ROW_WRITE,  REG_BOTH_CANCELS, 16'hFFFE, 1'b0, 1'b0, 32'd0, 1'b0, '0},
    // one item: a step wraps onto the same index and still flags a change
    '{ROW_WRITE,  REG_ITEM_COUNT,   16'hFF01, 1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd800, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd801, 1'b0, '0},
    '{ROW_WRITE,  REG_HOLD_TIME,    16'hFFFF, 1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_WRITE,  REG_ITEM_COUNT,   16'hFFFF, 1'b0, 1'b0, 32'd0, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b1, 32'd900, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd901, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b1, 1'b0, 32'd902, 1'b0, '0},
    '{ROW_SAMPLE, REG_ITEM_COUNT, 16'h0, 1'b0, 1'b0, 32'd903, 1'b0, '0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [InDW-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OutDW-1:0]  m_axis_tdata;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdW-1:0] cfg_index_i;
  logic [CfgDW-1:0]  cfg_data_i;

  // predictor state
  logic [IdxW-1:0]  p_items;
  logic [HoldW-1:0] p_hold;
  logic             p_cancel;
  logic [IdxW-1:0]  p_sel;
  btn_state_t       p_nxt;
  btn_state_t       p_prv;

  nav_res_t    nav_exp_q[$];
  nav_res_t    nav_got;
  nav_res_t    nav_want;
  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned live_cnt = 0;
  logic        src_quiet = 1'b0;
  logic        snk_quiet = 1'b0;
  logic        sink_hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  two_button_short_long_press_nav_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // One button for one sample: hold timer, long pulse, short press on release.
  function automatic btn_result_t btn_step(btn_state_t s, logic down,
                                           logic [TimeW-1:0] now);
    btn_result_t      r;
    logic [TimeW-1:0] held;
    r = '0;
    r.nxt = s;
    held = now - s.hold_start;
    if (down) begin
      if (!s.was_down) begin
        r.nxt.hold_start = now;
        r.nxt.long_done  = 1'b0;
      end else if (!s.long_done && s.hold_start != '0 &&
                   held >= {{(TimeW-HoldW){1'b0}}, p_hold}) begin
        r.long_pulse    = 1'b1;
        r.nxt.long_done = 1'b1;
      end
    end else begin
      r.short_press    = s.was_down && !s.long_done;
      r.nxt.hold_start = '0;
      r.nxt.long_done  = 1'b0;
    end
    r.nxt.was_down = down;
    return r;
  endfunction

  function automatic nav_res_t nav_predict(logic nd, logic pd, logic [TimeW-1:0] now);
    nav_res_t    r;
    btn_result_t nr;
    btn_result_t pr;
    r = '0;
    r.prev_idx = p_sel;
    if (p_items != '0) begin
      if (p_cancel && nd && pd) begin
        p_nxt = '0;
        p_prv = '0;
      end else begin
        nr = btn_step(p_nxt, nd, now);
        pr = btn_step(p_prv, pd, now);
        if (nr.short_press)
          p_sel = (p_sel + 1 < p_items) ? p_sel + 8'd1 : 8'd0;
        if (pr.short_press)
          p_sel = (p_sel != '0) ? p_sel - 8'd1 : p_items - 8'd1;
        r.changed  = nr.short_press || pr.short_press;
        r.open_sel = nr.long_pulse;
        r.go_back  = pr.long_pulse;
        p_nxt = nr.nxt;
        p_prv = pr.nxt;
      end
    end
    r.sel_idx = p_sel;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result %0d: %s got %0d want %0d", $realtime, res_cnt, what, got, want);
    err_cnt++;
  endtask

  // stop offering samples and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (nav_exp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_sample(input logic nd, input logic pd, input logic [TimeW-1:0] now,
                             input logic typed, input nav_res_t want);
    int unsigned gap;
    nav_res_t    pred;
    gap = src_quiet ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDW'({now, pd, nd});
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (p_items != '0) live_cnt++;
    pred = nav_predict(nd, pd, now);
    nav_exp_q.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdW-1:0] id, input logic [CfgDW-1:0] val);
    drain();
    // settle with no samples in flight before the write
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= id;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    case (id)
      REG_ITEM_COUNT: begin
        p_items = val[IdxW-1:0];
        p_sel   = '0;
        p_nxt   = '0;
        p_prv   = '0;
      end
      REG_HOLD_TIME:    p_hold = val;
      REG_BOTH_CANCELS: p_cancel = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      nav_got.sel_idx  = m_axis_tdata[7:0];
      nav_got.prev_idx = m_axis_tdata[15:8];
      nav_got.changed  = m_axis_tdata[16];
      nav_got.open_sel = m_axis_tdata[17];
      nav_got.go_back  = m_axis_tdata[18];
      if (nav_exp_q.size() == 0) begin
        report_mismatch("unexpected result, selected_index", nav_got.sel_idx, 0);
      end else begin
        nav_want = nav_exp_q.pop_front();
        if (nav_got.sel_idx != nav_want.sel_idx)
          report_mismatch("selected_index", nav_got.sel_idx, nav_want.sel_idx);
        if (nav_got.prev_idx != nav_want.prev_idx)
          report_mismatch("previous_index", nav_got.prev_idx, nav_want.prev_idx);
        if (nav_got.changed != nav_want.changed)
          report_mismatch("selection_changed", nav_got.changed, nav_want.changed);
        if (nav_got.open_sel != nav_want.open_sel)
          report_mismatch("open_selected", nav_got.open_sel, nav_want.open_sel);
        if (nav_got.go_back != nav_want.go_back)
          report_mismatch("go_back", nav_got.go_back, nav_want.go_back);
      end
      res_cnt++;
    end
  end

  // result sink with random stalls and one long hold-off on request
  initial begin : sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end
      stall = snk_quiet ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  initial begin : stim
    int               ph;
    int               i;
    int               n;
    int unsigned      span;
    logic             nd;
    logic             pd;
    logic [TimeW-1:0] t;
    logic [15:0]      junk;
    logic [IdxW-1:0]  cnt;
    logic [HoldW-1:0] hold;
    logic             cancel;
    int unsigned      pick;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_ITEM_COUNT;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    p_items  = '0;
    p_hold   = HOLD_TIME_RESET;
    p_cancel = 1'b0;
    p_sel    = '0;
    p_nxt    = '0;
    p_prv    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].kind == ROW_WRITE)
        cfg_write(DIR_TAB[i].reg_id, DIR_TAB[i].val);
      else
        send_sample(DIR_TAB[i].nd, DIR_TAB[i].pd, DIR_TAB[i].now,
                    DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    live_cnt = 0;
    for (ph = 0; live_cnt < RAND_ITEMS; ph++) begin
      if (ph == 0) begin
        cnt = 8'd255; hold = 16'd1; cancel = 1'b0;
      end else if (ph == 1) begin
        cnt = 8'd1; hold = 16'hFFFF; cancel = 1'b1;
      end else if (ph == 2) begin
        cnt = 8'd2; hold = 16'd0; cancel = 1'b0;
      end else begin
        pick = $urandom_range(0, 11);
        cnt = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : (pick == 2) ? 8'd255 :
              8'($urandom_range(2, 16));
        pick = $urandom_range(0, 9);
        hold = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'hFFFF :
               (pick == 3) ? 16'($urandom()) : 16'($urandom_range(2, 60));
        cancel = 1'($urandom_range(0, 1));
      end
      junk = 16'($urandom());
      if (ph < 3 || $urandom_range(0, 1) == 1)
        cfg_write(REG_ITEM_COUNT, {junk[15:8], cnt});
      if (ph < 3 || $urandom_range(0, 1) == 1)
        cfg_write(REG_HOLD_TIME, hold);
      if (ph < 3 || $urandom_range(0, 1) == 1)
        cfg_write(REG_BOTH_CANCELS, {junk[15:1], cancel});
      if ($urandom_range(0, 7) == 0)
        cfg_write(REG_UNUSED, 16'($urandom()));

      src_quiet = (ph == 3) || ($urandom_range(0, 3) == 0);
      snk_quiet = (ph == 3) || ($urandom_range(0, 3) == 0);

      pick = $urandom_range(0, 3);
      t = (pick == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) :
          (pick == 1) ? 32'd0 : $urandom();
      nd = 1'b0;
      pd = 1'b0;
      n = (p_items == '0) ? 20 : 145;
      for (i = 0; i < n; i++) begin
        // receiver backs off while the sender keeps offering
        if (ph == 3 && i == 10) sink_hold_req = 1'b1;
        if (ph == 4 && i == 70) drain();
        if ($urandom_range(0, 4) == 0) nd = ~nd;
        if ($urandom_range(0, 4) == 0) pd = ~pd;
        // time steps scale with the hold time so both press kinds occur
        span = p_hold / 3 + 3;
        t = t + $urandom_range(0, span);
        if ($urandom_range(0, 19) == 0) t = $urandom();
        else if ($urandom_range(0, 39) == 0) t = '0;
        send_sample(nd, pd, t, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
